// File: sv/teq_pkg.sv
`timescale 1ns / 1ps

package teq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 4;
    localparam int ID_COUNT        = 16;
    localparam int TIME_W          = 64;

    typedef enum logic [1:0] {
        REQ_ENQ = 2'd0,
        REQ_DEQ = 2'd1,
        REQ_REM = 2'd2,
        REQ_NOP = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EV,
        ST_PUT,
        ST_HEAD_RD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due;
    } t_slot;

    typedef struct packed {
        logic gt;
        logic id_eq;
    } t_cmp;

endpackage

// File: sv/timed_entry_queue_core.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+------------------------------------------
// in      | sink      | i_in_valid / o_in_stall  | i_req_type, i_entry_id, i_exec_time,
//         |           |                        | i_now_time
// out     | source    | o_out_valid / i_out_stall| o_accepted, o_taken_id, o_head_valid,
//         |           |                        | o_head_time
//
// One beat in, one beat out. Slots are scanned through a slot RAM with one read port
// and one write port and one shared compare unit; each slot is read, then evaluated.
// Enqueue scans from the tail and moves later entries back one slot; a dequeue that
// takes the head, and a remove of a queued id, shift the rest down by one slot.
// Synchronous active-low reset empties the queue; slot RAM is not cleared.
// A stalled output beat holds; the next request runs and waits in its last cycle.

module timed_entry_queue_core
    import teq_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [ID_W-1:0]   i_entry_id,
    input  logic [TIME_W-1:0] i_exec_time,
    input  logic [TIME_W-1:0] i_now_time,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_accepted,
    output logic [ID_W-1:0]   o_taken_id,
    output logic              o_head_valid,
    output logic [TIME_W-1:0] o_head_time
);

    localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CW = $clog2(QueueDepth + 1);

    // control state
    t_state              r_state, n_state;
    t_req                r_op, n_op;
    logic [AW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_count, n_count;
    logic                r_found, n_found;
    logic                r_ok, n_ok;
    logic [ID_COUNT-1:0] r_queued, n_queued;   // per-id "queued" flag
    logic                r_out_valid;

    // payload
    logic [ID_W-1:0]     r_id, n_id;
    logic [TIME_W-1:0]   r_key, n_key;         // due time (enqueue) or now (dequeue)
    logic [ID_W-1:0]     r_taken, n_taken;
    logic                r_o_accepted;
    logic [ID_W-1:0]     r_o_taken_id;
    logic                r_o_head_valid;
    logic [TIME_W-1:0]   r_o_head_time;

    // slot RAM ports
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_slot               wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    t_slot               rd_data;
    t_cmp                cmp;

    logic in_acc;
    logic out_free;
    logic is_last;
    logic enq_bad;
    t_req in_req;

    assign in_req   = t_req'(i_req_type);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_last  = r_idx == AW'(r_count - CW'(1));
    assign enq_bad  = (i_exec_time == '0) || r_queued[i_entry_id]
                      || (r_count == CW'(QueueDepth));

    teq_slot_mem #(
        .Depth (QueueDepth)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    teq_cmp u_cmp (
        .i_slot (rd_data),
        .i_key  (r_key),
        .i_id   (r_id),
        .o_cmp  (cmp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_req)
                        REQ_ENQ: begin
                            if (enq_bad) begin
                                n_state = ST_HEAD_RD;
                            end else if (r_count == '0) begin
                                n_state = ST_PUT;
                            end else begin
                                n_state = ST_RD;
                            end
                        end
                        REQ_DEQ: n_state = (r_count == '0) ? ST_HEAD_RD : ST_RD;
                        REQ_REM: n_state = r_queued[i_entry_id] ? ST_RD : ST_HEAD_RD;
                        default: n_state = ST_HEAD_RD;
                    endcase
                end
            end
            ST_RD: n_state = ST_EV;
            ST_EV: begin
                case (r_op)
                    REQ_ENQ: begin
                        if (!cmp.gt) begin
                            n_state = ST_HEAD_RD;
                        end else if (r_idx == '0) begin
                            n_state = ST_PUT;
                        end else begin
                            n_state = ST_RD;
                        end
                    end
                    REQ_DEQ: begin
                        if (cmp.gt || r_count == CW'(1)) begin
                            n_state = ST_HEAD_RD;
                        end else begin
                            n_state = ST_RD;
                        end
                    end
                    REQ_REM: n_state = is_last ? ST_HEAD_RD : ST_RD;
                    default: n_state = ST_HEAD_RD;
                endcase
            end
            ST_PUT:     n_state = ST_HEAD_RD;
            ST_HEAD_RD: n_state = ST_OUT;
            ST_OUT:     n_state = out_free ? ST_IDLE : ST_OUT;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_op     = r_op;
        n_id     = r_id;
        n_key    = r_key;
        n_idx    = r_idx;
        n_count  = r_count;
        n_found  = r_found;
        n_ok     = r_ok;
        n_taken  = r_taken;
        n_queued = r_queued;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = rd_data;
        rd_en    = 1'b0;
        rd_addr  = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_op    = in_req;
                    n_id    = i_entry_id;
                    n_ok    = 1'b0;
                    n_taken = '0;
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_key   = (in_req == REQ_DEQ) ? i_now_time : i_exec_time;
                    if (in_req == REQ_ENQ && r_count != '0) begin
                        // insertion scans from the tail toward the head
                        n_idx = AW'(r_count - CW'(1));
                    end
                end
            end
            ST_RD: begin
                rd_en = 1'b1;
            end
            ST_EV: begin
                case (r_op)
                    REQ_ENQ: begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(r_idx + AW'(1));
                        if (cmp.gt) begin
                            // later entry moves back one slot
                            wr_data = rd_data;
                            if (r_idx != '0) begin
                                n_idx = AW'(r_idx - AW'(1));
                            end
                        end else begin
                            wr_data.id  = r_id;
                            wr_data.due = r_key;
                            n_count     = CW'(r_count + CW'(1));
                            n_queued[r_id] = 1'b1;
                            n_ok        = 1'b1;
                        end
                    end
                    REQ_DEQ: begin
                        if (!cmp.gt) begin
                            n_taken = rd_data.id;
                            n_id    = rd_data.id;
                            n_ok    = 1'b1;
                            if (r_count == CW'(1)) begin
                                n_count = '0;
                                n_queued[rd_data.id] = 1'b0;
                            end else begin
                                // close the gap at the head via the remove pass
                                n_op    = REQ_REM;
                                n_found = 1'b1;
                                n_idx   = AW'(1);
                            end
                        end
                    end
                    REQ_REM: begin
                        if (r_found) begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(r_idx - AW'(1));
                        end
                        if (is_last) begin
                            n_count        = CW'(r_count - CW'(1));
                            n_queued[r_id] = 1'b0;
                            n_ok           = 1'b1;
                        end else begin
                            n_found = r_found || cmp.id_eq;
                            n_idx   = AW'(r_idx + AW'(1));
                        end
                    end
                    default: ;
                endcase
            end
            ST_PUT: begin
                wr_en          = 1'b1;
                wr_data.id     = r_id;
                wr_data.due    = r_key;
                n_count        = CW'(r_count + CW'(1));
                n_queued[r_id] = 1'b1;
                n_ok           = 1'b1;
            end
            ST_HEAD_RD: begin
                rd_en   = r_count != '0;
                rd_addr = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= REQ_NOP;
            r_idx    <= '0;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_ok     <= 1'b0;
            r_queued <= '0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_found  <= n_found;
            r_ok     <= n_ok;
            r_queued <= n_queued;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_key   <= n_key;
        r_taken <= n_taken;
    end

    // output register: the next request proceeds while a beat waits here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_o_accepted   <= r_ok;
            r_o_taken_id   <= r_taken;
            r_o_head_valid <= r_count != '0;
            r_o_head_time  <= (r_count != '0) ? rd_data.due : '0;
        end
    end

    assign o_in_stall   = r_state != ST_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_accepted   = r_o_accepted;
    assign o_taken_id   = r_o_taken_id;
    assign o_head_valid = r_o_head_valid;
    assign o_head_time  = r_o_head_time;

    // queued-id flags track the fill count
    a_count_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_queued) == int'(r_count))
        else $error("queued id flags disagree with queue count");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QueueDepth))
        else $error("queue count beyond depth");

    a_empty_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_head_valid |-> o_head_time == '0)
        else $error("empty queue reports nonzero head time");

    a_taken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_taken_id != '0 |-> o_accepted)
        else $error("taken id without accepted beat");

endmodule

// File: sv/teq_slot_mem.sv
`timescale 1ns / 1ps

module teq_slot_mem
    import teq_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH_DEF,
    localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot         o_rd_data
);

    t_slot r_mem [Depth];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/teq_cmp.sv
`timescale 1ns / 1ps

module teq_cmp
    import teq_pkg::*;
(
    input  t_slot           i_slot,
    input  logic [TIME_W-1:0] i_key,
    input  logic [ID_W-1:0] i_id,
    output t_cmp            o_cmp
);

    // single 64-bit magnitude compare, shared by enqueue and dequeue
    always_comb begin
        o_cmp.gt    = i_slot.due > i_key;
        o_cmp.id_eq = i_slot.id == i_id;
    end

endmodule

// File: tb/sv/timed_entry_queue_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the timer queue, keeps its own copy of the
// queue and compares every result beat with the oldest prediction.
module timed_entry_queue_checker
    import teq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [ID_W-1:0]   i_entry_id,
    input  logic [TIME_W-1:0] i_exec_time,
    input  logic [TIME_W-1:0] i_now_time,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_accepted,
    input  logic [ID_W-1:0]   i_taken_id,
    input  logic              i_head_valid,
    input  logic [TIME_W-1:0] i_head_time,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic              accepted;
        logic [ID_W-1:0]   taken_id;
        logic              head_valid;
        logic [TIME_W-1:0] head_time;
    } timer_result_t;

    // predicted queue contents, sorted by due time
    t_slot             sorted_slots [QUEUE_DEPTH_DEF];
    logic [TIME_W-1:0] due_of_id [ID_COUNT];
    int                n_queued;

    timer_result_t     awaited_results [$];

    task automatic drop_entry(input int pos);
        int k;
        due_of_id[sorted_slots[pos].id] = '0;
        for (k = pos; k + 1 < n_queued; k++) begin
            sorted_slots[k] = sorted_slots[k + 1];
        end
        n_queued--;
    endtask

    task automatic step_timer_queue(input t_req req, input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] due,
                                    input logic [TIME_W-1:0] now,
                                    output timer_result_t res);
        int   pos;
        int   k;
        logic ok;
        logic found;
        ok           = 1'b0;
        found        = 1'b0;
        res.taken_id = '0;
        case (req)
            REQ_ENQ: begin
                if (due != '0 && due_of_id[id] == '0 && n_queued < QUEUE_DEPTH_DEF) begin
                    // equal times go behind the ones already queued
                    pos = 0;
                    while (pos < n_queued && sorted_slots[pos].due <= due) pos++;
                    for (k = n_queued; k > pos; k--) begin
                        sorted_slots[k] = sorted_slots[k - 1];
                    end
                    sorted_slots[pos].id  = id;
                    sorted_slots[pos].due = due;
                    n_queued++;
                    due_of_id[id] = due;
                    ok = 1'b1;
                end
            end
            REQ_DEQ: begin
                if (n_queued > 0 && now >= sorted_slots[0].due) begin
                    res.taken_id = sorted_slots[0].id;
                    drop_entry(0);
                    ok = 1'b1;
                end
            end
            REQ_REM: begin
                for (pos = 0; pos < n_queued && !found; pos++) begin
                    if (sorted_slots[pos].id == id) begin
                        drop_entry(pos);
                        found = 1'b1;
                    end
                end
                ok = found;
            end
            default: begin
            end
        endcase
        res.accepted   = ok;
        res.head_valid = (n_queued > 0);
        res.head_time  = (n_queued > 0) ? sorted_slots[0].due : '0;
    endtask

    always @(posedge i_clk) begin : watch
        timer_result_t want;
        timer_result_t fresh;
        logic          bad;
        bad = 1'b0;
        if (!i_rst_n) begin
            n_queued = 0;
            foreach (due_of_id[i]) due_of_id[i] = '0;
            awaited_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with no request outstanding", $time);
                    bad = 1'b1;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_accepted !== want.accepted) begin
                        $display("%0t: accepted expected %0b actual %0b",
                                 $time, want.accepted, i_accepted);
                        bad = 1'b1;
                    end
                    if (i_taken_id !== want.taken_id) begin
                        $display("%0t: taken_id expected %0d actual %0d",
                                 $time, want.taken_id, i_taken_id);
                        bad = 1'b1;
                    end
                    if (i_head_valid !== want.head_valid) begin
                        $display("%0t: head_valid expected %0b actual %0b",
                                 $time, want.head_valid, i_head_valid);
                        bad = 1'b1;
                    end
                    if (i_head_time !== want.head_time) begin
                        $display("%0t: head_time expected %h actual %h",
                                 $time, want.head_time, i_head_time);
                        bad = 1'b1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_timer_queue(t_req'(i_req_type), i_entry_id, i_exec_time, i_now_time,
                                 fresh);
                awaited_results.push_back(fresh);
            end
        end
        if (bad) o_fail_count <= o_fail_count + 1;
        o_pending <= awaited_results.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the timer queue. Prediction and comparison live
// in the checker instance; this module only makes beats and handles pacing.
module testbench;
    import teq_pkg::*;

    localparam int RANDOM_ITEMS   = 600;  // random beats per pacing phase
    localparam int BURST_ITEMS    = 40;   // beats offered while the sink holds off
    localparam int RX_HOLD_CYCLES = 300;  // length of the long sink hold-off
    localparam int DRAIN_TAIL     = 40;   // extra cycles after the last result
    localparam int QUIET_LIMIT    = 3000; // cycles without any beat before giving up

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [1:0]        i_req_type  = REQ_NOP;
    logic [ID_W-1:0]   i_entry_id  = '0;
    logic [TIME_W-1:0] i_exec_time = '0;
    logic [TIME_W-1:0] i_now_time  = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_accepted;
    logic [ID_W-1:0]   o_taken_id;
    logic              o_head_valid;
    logic [TIME_W-1:0] o_head_time;

    int                fail_count;
    int                pending;

    // pacing knobs: sender idle odds (used by the stimulus process only)
    // and sink stall odds (read by the sink process)
    int                tx_idle_pct  = 0;
    int                rx_idle_pct  = 0;

    // long hold-off requests: stimulus bumps asks, sink catches up
    int                hold_asks    = 0;
    int                hold_served  = 0;
    int                hold_left    = 0;

    // monotonic time base for the random part; keeps most entries due soon
    logic [TIME_W-1:0] sim_now      = 64'd1;

    int unsigned       quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    timed_entry_queue_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_entry_id  (i_entry_id),
        .i_exec_time (i_exec_time),
        .i_now_time  (i_now_time),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_accepted  (o_accepted),
        .o_taken_id  (o_taken_id),
        .o_head_valid(o_head_valid),
        .o_head_time (o_head_time)
    );

    timed_entry_queue_checker u_result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_entry_id  (i_entry_id),
        .i_exec_time (i_exec_time),
        .i_now_time  (i_now_time),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_accepted  (o_accepted),
        .i_taken_id  (o_taken_id),
        .i_head_valid(o_head_valid),
        .i_head_time (o_head_time),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Sink side. A pending hold-off request wins over random stalls and
    // keeps the output stalled until its hold-off count runs out.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_asks) begin
            hold_served <= hold_asks;
            hold_left   <= RX_HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // Offers one request beat and returns at the edge that takes it. Random
    // idle cycles go in front; valid only drops when an idle cycle is chosen,
    // so back-to-back beats keep valid high.
    task automatic send_request(input t_req req, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] due,
                                input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_entry_id  <= id;
        i_exec_time <= due;
        i_now_time  <= now;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Mostly well-formed traffic: due times a little ahead of the time base
    // (plenty of ties), dequeues at the current time so the head really
    // comes due. The rest is zero, all-ones and fully random times.
    task automatic send_random_request();
        t_req              req;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] now;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 45)      req = REQ_ENQ;
        else if (pick < 75) req = REQ_DEQ;
        else if (pick < 95) req = REQ_REM;
        else                req = REQ_NOP;
        id = ID_W'($urandom_range(ID_COUNT - 1));
        sim_now = sim_now + $urandom_range(12);
        pick = $urandom_range(99);
        if (pick < 75)      due = sim_now + $urandom_range(40);
        else if (pick < 88) due = {$urandom, $urandom};
        else if (pick < 94) due = '0;
        else                due = '1;
        pick = $urandom_range(99);
        if (pick < 85)      now = sim_now;
        else if (pick < 93) now = '1;   // drains far-future entries too
        else                now = {$urandom, $urandom};
        send_request(req, id, due, now);
    endtask

    // Stop offering and wait until every predicted result has come back.
    // The first edge lets the checker count the last beat sent.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 35;
        rx_idle_pct <= 53;

        // Directed part: empty-queue cases, unused code, refusals, ties,
        // not-yet-due head, remove from the tail and the middle, full queue.
        send_request(REQ_DEQ, 4'd0,  '0,    '1);     // dequeue from empty queue
        send_request(REQ_REM, 4'd0,  '0,    '0);     // remove, nothing queued
        send_request(REQ_NOP, 4'd15, '1,    '1);     // unused code, all ones
        send_request(REQ_ENQ, 4'd5,  '0,    '0);     // zero due time refused
        send_request(REQ_ENQ, 4'd0,  '1,    '0);     // latest possible time
        send_request(REQ_ENQ, 4'd15, 64'd1, '0);
        send_request(REQ_ENQ, 4'd3,  64'd1, '0);     // tie: goes behind id 15
        send_request(REQ_ENQ, 4'd15, 64'd7, '0);     // id already queued
        send_request(REQ_DEQ, 4'd0,  '0,    '0);     // head not yet due
        send_request(REQ_DEQ, 4'd0,  '0,    64'd1);  // due exactly now
        send_request(REQ_REM, 4'd0,  '0,    '0);     // remove the tail entry
        // fill every id; id 3 is refused as a duplicate, the queue ends full
        for (int i = 0; i < ID_COUNT; i++) begin
            send_request(REQ_ENQ, ID_W'(i), TIME_W'(40 + (i % 4) * 10), '0);
        end
        send_request(REQ_ENQ, 4'd9,  64'd2, '0);     // full queue refuses
        send_request(REQ_REM, 4'd8,  '0,    '0);     // remove from the middle
        send_request(REQ_DEQ, 4'd0,  '0,    '1);
        wait_for_drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 35;
                    rx_idle_pct <= 53;
                end
                1: begin
                    tx_idle_pct = 53;
                    rx_idle_pct <= 35;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    // long sink hold-off while beats keep coming: the block
                    // fills and must stall its input
                    hold_asks <= hold_asks + 1;
                    repeat (BURST_ITEMS) send_random_request();
                    wait_for_drain();
                end
            endcase
            repeat (RANDOM_ITEMS) send_random_request();
            wait_for_drain();
        end

        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
